// File: rtl/fir9rp_pkg.sv
// shared types, constants and coefficients of the nine-tap filter peripheral
`default_nettype none

package fir9rp_pkg;

  // data path widths
  localparam int DATA_W         = 32;
  localparam int TAPS           = 9;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;
  localparam int PROD_W         = DATA_W + COEF_W;
  localparam int GRP_W          = PROD_W + 2;
  localparam int ACC_W          = PROD_W + 4;
  localparam int GROUPS         = 3;
  localparam int GROUP_SIZE     = TAPS / GROUPS;

  // result queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // byte lane mask for a full-word write
  localparam logic [3:0] BE_ALL = 4'hF;

  // coefficients: round(c * 2^frac) with halves away from zero
  localparam longint COEF_SCALE = 100000;
  localparam longint CQ_OUTER = ((longint'(6) << COEF_FRAC_BITS) + COEF_SCALE / 2) / COEF_SCALE;
  localparam longint CQ_SIDE  = ((longint'(1265) << COEF_FRAC_BITS) + COEF_SCALE / 2)
                                / COEF_SCALE;
  localparam longint CQ_NEAR  = ((longint'(2011) << COEF_FRAC_BITS) + COEF_SCALE / 2)
                                / COEF_SCALE;
  localparam longint CQ_INNER = ((longint'(50403) << COEF_FRAC_BITS) + COEF_SCALE / 2)
                                / COEF_SCALE;
  localparam longint CQ_MID   = ((longint'(97714) << COEF_FRAC_BITS) + COEF_SCALE / 2)
                                / COEF_SCALE;

  localparam logic signed [COEF_W-1:0] COEF [TAPS] = '{
    COEF_W'(-CQ_OUTER), COEF_W'(-CQ_SIDE), COEF_W'(CQ_NEAR), COEF_W'(CQ_INNER),
    COEF_W'(CQ_MID),
    COEF_W'(CQ_INNER), COEF_W'(CQ_NEAR), COEF_W'(-CQ_SIDE), COEF_W'(-CQ_OUTER)
  };

  // rounding offset, half an output lsb
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(longint'(1) << (COEF_FRAC_BITS - 1));

  // bus access kinds
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_IGNORE = 2'd2
  } cmd_e;

  // register map
  typedef enum logic [1:0] {
    REG_SAMPLE  = 2'd0,
    REG_RESULT  = 2'd1,
    REG_COUNT   = 2'd2,
    REG_INVALID = 2'd3
  } reg_e;

  // response codes
  typedef enum logic [1:0] {
    RESP_OK    = 2'd0,
    RESP_ERROR = 2'd1,
    RESP_FULL  = 2'd2
  } resp_e;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic              push;
    logic              pop;
    resp_e             resp;
    logic [FILL_W-1:0] imm;
  } ctrl_t;

  // item handed to the queue and output stage
  typedef struct packed {
    ctrl_t                    ctrl;
    logic signed [DATA_W-1:0] result;
  } q_entry_t;

endpackage

`default_nettype wire

// File: rtl/fir9rp_if.sv
// request and response channel interfaces
`default_nettype none

interface fir9rp_req_if;
  import fir9rp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [1:0]               reg_index;
  logic signed [DATA_W-1:0] write_data;
  logic [3:0]               byte_enables;

  modport source (output valid, output command, output reg_index, output write_data,
                  output byte_enables, input ready);
  modport sink (input valid, input command, input reg_index, input write_data,
                input byte_enables, output ready);
endinterface

interface fir9rp_rsp_if;
  import fir9rp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic [1:0]               response;

  modport source (output valid, output read_data, output response, input ready);
  modport sink (input valid, input read_data, input response, output ready);
endinterface

`default_nettype wire

// File: rtl/fir9rp_tap_cell.sv
// one delay line cell: holds a sample and its weighted product
`default_nettype none

module fir9rp_tap_cell (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 shift_i,
  input  wire logic signed [fir9rp_pkg::DATA_W-1:0] tap_i,
  input  wire logic signed [fir9rp_pkg::COEF_W-1:0] coef_i,
  output logic signed [fir9rp_pkg::DATA_W-1:0]      tap_o,
  output logic signed [fir9rp_pkg::PROD_W-1:0]      prod_o
);
  import fir9rp_pkg::*;

  logic signed [DATA_W-1:0] tap_q;
  logic signed [PROD_W-1:0] prod_q;

  // sample register, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= tap_i;
    end
  end

  // product of the incoming sample with this cell's weight
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      prod_q <= PROD_W'(tap_i) * PROD_W'(coef_i);
    end
  end

  assign tap_o  = tap_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: rtl/fir9rp_queue.sv
// result queue memory and response output register
`default_nettype none

module fir9rp_queue (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 load_i,
  input  wire fir9rp_pkg::q_entry_t                 entry_i,
  output logic                                      ready_o,
  output logic                                      valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [fir9rp_pkg::DATA_W-1:0]      read_data_o,
  output fir9rp_pkg::resp_e                         response_o
);
  import fir9rp_pkg::*;

  logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0]        head_q, head_d;
  logic [QIDX_W-1:0]        tail_q, tail_d;
  logic                     valid_q;
  logic signed [DATA_W-1:0] rdata_q;
  resp_e                    resp_q;

  // output register frees when empty or taken
  assign ready_o = !valid_q || out_ready_i;

  // pointer wrap
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (load_i && entry_i.ctrl.pop) begin
      head_d = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QIDX_W'(1);
    end
    if (load_i && entry_i.ctrl.push) begin
      tail_d = (tail_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QIDX_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // queue write port
  always_ff @(posedge clk_i) begin
    if (load_i && entry_i.ctrl.push) begin
      mem[tail_q] <= entry_i.result;
    end
  end

  // registered read and response
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      resp_q <= entry_i.ctrl.resp;
      if (entry_i.ctrl.pop) begin
        rdata_q <= mem[head_q];
      end else begin
        rdata_q <= DATA_W'(entry_i.ctrl.imm);
      end
    end
  end

  assign valid_o     = valid_q;
  assign read_data_o = rdata_q;
  assign response_o  = resp_q;

endmodule

`default_nettype wire

// File: rtl/fir9_filter_register_peripheral.sv
// Nine-tap FIR peripheral with a register-style request/response bus.
// Requests arrive on req_i (command, reg_index, write_data, byte_enables);
// exactly one response per request leaves on rsp_o (read_data, response).
// A full-lane write to the sample register, unless the queue is full,
// shifts the sample into a chain of nine tap cells, each of which
// multiplies its new sample by a fixed weight; the products are summed,
// rounded and saturated to Q16.16 and the result is pushed into a
// 16-entry queue. A read of the result register pops that queue, a read
// of the count register gives its fill. The response is registered in
// turn by the tap cells, group sums, round/saturate and output register.
// Throughput is one request per cycle while the receiver keeps taking
// responses. When the receiver stalls, the stages behind the output
// register keep filling until every stage is held, then req_i.ready drops.
// Reset clears the delay line to zero, empties the queue and the pipeline;
// the queue storage itself is not cleared, no clearing pass is needed.
`default_nettype none

module fir9_filter_register_peripheral (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fir9rp_req_if.sink  req_i,
  fir9rp_rsp_if.source rsp_o
);
  import fir9rp_pkg::*;

  logic                     accept;
  logic                     ready1, ready2, ready3, q_ready;
  logic                     mv1, mv2, mv3;
  logic                     v1_q, v2_q, v3_q;
  ctrl_t                    ctrl_d, ctrl1_q, ctrl2_q, ctrl3_q;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic signed [DATA_W-1:0] tap [TAPS];
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [GRP_W-1:0]  grp_d [GROUPS];
  logic signed [GRP_W-1:0]  grp_q [GROUPS];
  logic signed [ACC_W-1:0]  acc, acc_sh;
  logic signed [DATA_W-1:0] res_d, res3_q;
  logic                     fits;
  q_entry_t                 q_entry;
  resp_e                    response;

  // stage handshake, each stage moves when the next one can take it
  assign ready3 = !v3_q || q_ready;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign mv3    = v3_q && q_ready;
  assign mv2    = v2_q && ready3;
  assign mv1    = v1_q && ready2;

  assign req_i.ready = ready1;
  assign accept      = req_i.valid && ready1;

  // request decode against the fill at acceptance
  always_comb begin
    ctrl_d = '{push: 1'b0, pop: 1'b0, resp: RESP_OK, imm: '0};
    case (req_i.command)
      CMD_READ: begin
        if (req_i.reg_index == REG_RESULT) begin
          ctrl_d.pop = (fill_q != '0);
        end else if (req_i.reg_index == REG_COUNT) begin
          ctrl_d.imm = fill_q;
        end
      end
      CMD_WRITE: begin
        if (req_i.reg_index == REG_SAMPLE && req_i.byte_enables == BE_ALL) begin
          if (fill_q == FILL_W'(QUEUE_DEPTH)) begin
            ctrl_d.resp = RESP_FULL;
          end else begin
            ctrl_d.push = 1'b1;
          end
        end
      end
      default: begin
        ctrl_d.resp = RESP_ERROR;
      end
    endcase
  end

  // queue fill count
  always_comb begin
    fill_d = fill_q;
    if (accept && ctrl_d.push) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (accept && ctrl_d.pop) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  // chain of tap cells, newest sample in cell zero
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == 0) begin : g_head
      fir9rp_tap_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept && ctrl_d.push),
        .tap_i   (req_i.write_data),
        .coef_i  (COEF[i]),
        .tap_o   (tap[i]),
        .prod_o  (prod[i])
      );
    end else begin : g_body
      fir9rp_tap_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept && ctrl_d.push),
        .tap_i   (tap[i-1]),
        .coef_i  (COEF[i]),
        .tap_o   (tap[i]),
        .prod_o  (prod[i])
      );
    end
  end

  // group sums of three neighboring products
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = GRP_W'(prod[g*GROUP_SIZE]) + GRP_W'(prod[g*GROUP_SIZE + 1])
               + GRP_W'(prod[g*GROUP_SIZE + 2]);
    end
  end

  // final sum, round half up, saturate to the data width
  assign acc    = ACC_W'(grp_q[0]) + ACC_W'(grp_q[1]) + ACC_W'(grp_q[2]) + ROUND_HALF;
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  assign fits   = (&acc_sh[ACC_W-1:DATA_W-1]) || !(|acc_sh[ACC_W-1:DATA_W-1]);

  always_comb begin
    if (fits) begin
      res_d = acc_sh[DATA_W-1:0];
    end else if (acc_sh[ACC_W-1]) begin
      res_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // stage valids and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (ready1) begin
        v1_q <= req_i.valid;
      end
      if (ready2) begin
        v2_q <= mv1;
      end
      if (ready3) begin
        v3_q <= mv2;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl1_q <= ctrl_d;
    end
    if (mv1) begin
      ctrl2_q <= ctrl1_q;
      grp_q   <= grp_d;
    end
    if (mv2) begin
      ctrl3_q <= ctrl2_q;
      res3_q  <= res_d;
    end
  end

  // queue and output register
  assign q_entry = '{ctrl: ctrl3_q, result: res3_q};

  fir9rp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (mv3),
    .entry_i     (q_entry),
    .ready_o     (q_ready),
    .valid_o     (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .read_data_o (rsp_o.read_data),
    .response_o  (response)
  );

  assign rsp_o.response = response;

endmodule

`default_nettype wire

// File: tb/fir9_filter_register_peripheral_test.sv
// testbench of the nine-tap filter peripheral: bus accesses checked against a filter model
`timescale 1ns / 1ps

module fir9_filter_register_peripheral_test;
  import fir9rp_pkg::*;

  localparam int          CLK_HALF      = 4;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 8;
  localparam logic [1:0]  CMD_RESERVED  = 2'd3;
  localparam logic [31:0] SAMPLE_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] SAMPLE_MIN    = 32'h8000_0000;

  // filter weights scaled by 1e5, outer tap first
  localparam int WEIGHT_X1E5 [TAPS] = '{-6, -1265, 2011, 50403, 97714, 50403, 2011, -1265, -6};

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [1:0]        resp;
  } bus_reply_t;

  logic clk_i;
  logic rst_ni;

  fir9rp_req_if req_if ();
  fir9rp_rsp_if rsp_if ();

  fir9_filter_register_peripheral u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // filter model state
  longint                    weight_q [TAPS];
  logic signed [DATA_W-1:0]  delay_line [TAPS];
  logic signed [DATA_W-1:0]  filter_results [$];
  bus_reply_t                pending_replies [$];

  int error_count;
  int idle_en;
  int rx_hold;
  int rx_run;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // weight quantization, halves away from zero
  function automatic longint quantize_weight(input int x1e5);
    longint mag;
    mag = (x1e5 < 0) ? -longint'(x1e5) : longint'(x1e5);
    mag = ((mag << COEF_FRAC_BITS) + 50000) / 100000;
    return (x1e5 < 0) ? -mag : mag;
  endfunction

  // dot product, rounded half up and saturated to q16.16
  function automatic logic signed [DATA_W-1:0] fir_output();
    longint acc;
    longint rounded;
    int     j;
    acc = 0;
    for (j = 0; j < TAPS; j++) acc += longint'(delay_line[TAPS-1-j]) * weight_q[j];
    rounded = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (rounded > longint'(32'sh7FFF_FFFF)) rounded = longint'(32'sh7FFF_FFFF);
    if (rounded < -longint'(32'sh7FFF_FFFF) - 1) rounded = -longint'(32'sh7FFF_FFFF) - 1;
    return DATA_W'(rounded);
  endfunction

  // reply of one bus access, updating the model state
  function automatic bus_reply_t predict_reply(input logic [1:0] cmd, input logic [1:0] idx,
                                               input logic [31:0] data, input logic [3:0] be);
    bus_reply_t r;
    int         k;
    r.data = '0;
    r.resp = RESP_OK;
    case (cmd)
      CMD_READ: begin
        if (idx == REG_RESULT) begin
          if (filter_results.size() > 0) r.data = filter_results.pop_front();
        end else if (idx == REG_COUNT) begin
          r.data = DATA_W'(filter_results.size());
        end
      end
      CMD_WRITE: begin
        if (idx == REG_SAMPLE && be == BE_ALL) begin
          if (filter_results.size() >= QUEUE_DEPTH) begin
            r.resp = RESP_FULL;
          end else begin
            for (k = TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
            delay_line[0] = data;
            filter_results.push_back(fir_output());
          end
        end
      end
      default: r.resp = RESP_ERROR;
    endcase
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample value with extremes and small values mixed in
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // offer one item and wait until it is taken
  task automatic send_access(input logic [1:0] cmd, input logic [1:0] idx,
                             input logic [31:0] data, input logic [3:0] be);
    int gap;
    gap = 0;
    if (idle_en != 0 && $urandom_range(0, 3) == 0) gap = idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.reg_index    <= idx;
    req_if.write_data   <= data;
    req_if.byte_enables <= be;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_replies.push_back(predict_reply(cmd, idx, data, be));
  endtask

  // one random access, biased toward filling or draining the queue
  task automatic send_random(input bit filling);
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) begin
      send_access(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                  4'($urandom_range(0, 15)));
    end else if (p < 18) begin
      send_access(CMD_READ, REG_COUNT, $urandom, 4'($urandom_range(0, 15)));
    end else if ((p < 80) == filling) begin
      send_access(CMD_WRITE, REG_SAMPLE, rand_sample(), BE_ALL);
    end else begin
      send_access(CMD_READ, REG_RESULT, $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  // register map, empty queue and error cases
  task automatic test_register_map();
    send_access(CMD_READ, REG_COUNT, 32'h0, 4'h0);
    send_access(CMD_READ, REG_RESULT, 32'h0, BE_ALL);
    send_access(CMD_READ, REG_SAMPLE, 32'hFFFF_FFFF, BE_ALL);
    send_access(CMD_READ, REG_INVALID, 32'h0, 4'h0);
    send_access(CMD_IGNORE, REG_SAMPLE, 32'h1234_5678, BE_ALL);
    send_access(CMD_RESERVED, REG_INVALID, 32'hFFFF_FFFF, BE_ALL);
    send_access(CMD_WRITE, REG_SAMPLE, 32'hFFFF_FFFF, 4'h7);
    send_access(CMD_WRITE, REG_SAMPLE, 32'h0001_0000, 4'h8);
    send_access(CMD_WRITE, REG_RESULT, 32'h0001_0000, BE_ALL);
    send_access(CMD_WRITE, REG_COUNT, 32'h0001_0000, BE_ALL);
    send_access(CMD_WRITE, REG_INVALID, 32'h0001_0000, BE_ALL);
  endtask

  // full-scale samples drive the output into saturation both ways
  task automatic test_saturation();
    repeat (5) send_access(CMD_WRITE, REG_SAMPLE, SAMPLE_MAX, BE_ALL);
    repeat (5) send_access(CMD_WRITE, REG_SAMPLE, SAMPLE_MIN, BE_ALL);
    send_access(CMD_WRITE, REG_SAMPLE, 32'h0, BE_ALL);
    send_access(CMD_READ, REG_COUNT, 32'h0, BE_ALL);
    repeat (3) send_access(CMD_READ, REG_RESULT, 32'h0, BE_ALL);
  endtask

  // fill until samples are refused, then drain past empty
  task automatic test_queue_full();
    while (filter_results.size() < QUEUE_DEPTH)
      send_access(CMD_WRITE, REG_SAMPLE, rand_sample(), BE_ALL);
    repeat (2) send_access(CMD_WRITE, REG_SAMPLE, rand_sample(), BE_ALL);
    send_access(CMD_READ, REG_COUNT, 32'h0, BE_ALL);
    while (filter_results.size() > 0)
      send_access(CMD_READ, REG_RESULT, $urandom, BE_ALL);
    send_access(CMD_READ, REG_RESULT, $urandom, BE_ALL);
    send_access(CMD_READ, REG_COUNT, 32'h0, BE_ALL);
  endtask

  // random mix swinging between full and empty queue
  task automatic test_random_traffic(input int n_items);
    bit filling;
    filling = 1'b1;
    repeat (n_items) begin
      if (filter_results.size() >= QUEUE_DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      if (filter_results.size() == 0) filling = 1'b1;
      if ($urandom_range(0, 39) == 0) filling = ~filling;
      send_random(filling);
    end
  endtask

  // random mix with no idling on either side
  task automatic test_back_to_back(input int n_items);
    idle_en = 0;
    test_random_traffic(n_items);
    idle_en = 1;
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_output_stall();
    idle_en = 0;
    rx_hold = 200;
    repeat (20) begin
      send_access(CMD_WRITE, REG_SAMPLE, rand_sample(), BE_ALL);
      send_access(CMD_READ, REG_RESULT, $urandom, BE_ALL);
    end
    idle_en = 1;
  endtask

  // receiver side ready pattern
  initial begin
    rsp_if.ready <= 1'b0;
    forever @(posedge clk_i) begin
      if (rx_hold > 0) begin
        rsp_if.ready <= 1'b0;
        rx_hold--;
      end else if (idle_en == 0) begin
        rsp_if.ready <= 1'b1;
      end else if (rx_run > 0) begin
        rx_run--;
      end else if ($urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        rx_run = idle_len();
      end else begin
        rsp_if.ready <= 1'b1;
        rx_run = $urandom_range(1, 12);
      end
    end
  end

  // compare each reply with the oldest prediction
  initial begin
    bus_reply_t exp_reply;
    forever @(posedge clk_i) begin
      if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply data %h resp %0d", $time, rsp_if.read_data,
                   rsp_if.response);
          error_count++;
        end else begin
          exp_reply = pending_replies.pop_front();
          if (rsp_if.read_data !== exp_reply.data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h", $time,
                     exp_reply.data, rsp_if.read_data);
            error_count++;
          end
          if (rsp_if.response !== exp_reply.resp) begin
            $display("%0t: response mismatch: expected %0d, actual %0d", $time,
                     exp_reply.resp, rsp_if.response);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever @(posedge clk_i) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d replies outstanding", $time, pending_replies.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    int k;
    error_count = 0;
    idle_en     = 1;
    rx_hold     = 0;
    rx_run      = 0;
    for (k = 0; k < TAPS; k++) begin
      weight_q[k]   = quantize_weight(WEIGHT_X1E5[k]);
      delay_line[k] = '0;
    end
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_READ;
    req_if.reg_index    <= REG_SAMPLE;
    req_if.write_data   <= '0;
    req_if.byte_enables <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_map();
    test_saturation();
    test_queue_full();
    test_random_traffic(380);
    test_back_to_back(100);
    test_output_stall();
    test_queue_full();
    test_random_traffic(60);

    // let the last replies come out
    req_if.valid <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
